// ===== hdl/reckd_pkg.sv =====
// package for the rotary encoder key decoder
// event codes, register indexes and default settings; no dependencies
`timescale 1ns / 1ps

package reckd_pkg;

  localparam int TICK_BITS_DEFAULT = 32;
  localparam int NOW_BITS          = 32;
  localparam int CFG_INDEX_BITS    = 8;
  localparam int CFG_DATA_BITS     = 16;
  localparam int EVENT_BITS        = 2;

  localparam logic [CFG_DATA_BITS-1:0] KEY_DEBOUNCE_RESET  = 16'd50;
  localparam logic [CFG_DATA_BITS-1:0] ROTATE_HOLDOFF_RESET = 16'd5;

  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_DEBOUNCE   = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROTATE_HOLDOFF = 8'd1;

  localparam logic [EVENT_BITS-1:0] ROT_NONE  = 2'd0;
  localparam logic [EVENT_BITS-1:0] ROT_RIGHT = 2'd1;
  localparam logic [EVENT_BITS-1:0] ROT_LEFT  = 2'd2;

  localparam logic [EVENT_BITS-1:0] KEY_NONE    = 2'd0;
  localparam logic [EVENT_BITS-1:0] KEY_PRESS   = 2'd1;
  localparam logic [EVENT_BITS-1:0] KEY_RELEASE = 2'd2;

endpackage

// ===== hdl/rotary_encoder_key_decoder_unit.sv =====
// Rotary encoder with push key: takes one pin poll per cycle and issues one result cycle at
// most per poll. A key level change opens a debounce window; once key_debounce_ticks have
// passed, the rechecked level is confirmed and a press or release is reported. Without a key
// event or a running debounce, a falling edge on phase A outside the rotation holdoff reports
// a right turn (B high) or a left turn (B low). Tick differences wrap modulo 2^TICK_BITS; the
// 32-bit now_tick is truncated or zero-extended to TICK_BITS. Each poll passes through the
// single compare-and-subtract path from the input to the state and result registers;
// polls with no event give no result. A two-entry output stage (result register plus skid)
// keeps taking polls while a result waits; in_stall rises only when both entries are full.
// Configuration writes are always ready and take effect on the next cycle.
// depends on reckd_pkg
`timescale 1ns / 1ps

module rotary_encoder_key_decoder_unit
  import reckd_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      phase_a,
  input  logic                      phase_b,
  input  logic                      key_level,
  input  logic                      key_recheck,
  input  logic [NOW_BITS-1:0]       now_tick,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [EVENT_BITS-1:0]     rotate_event,
  output logic [EVENT_BITS-1:0]     key_event
);

  logic [CFG_DATA_BITS-1:0] key_debounce_ticks;
  logic [CFG_DATA_BITS-1:0] rotate_holdoff_ticks;

  logic                 prev_phase_a;
  logic                 prev_key_level;
  logic                 key_is_pressed;
  logic                 debounce_active;
  logic [TICK_BITS-1:0] debounce_start_tick;
  logic [TICK_BITS-1:0] last_rotate_tick;

  logic                  skid_valid;
  logic [EVENT_BITS-1:0] skid_rotate;
  logic [EVENT_BITS-1:0] skid_key;

  logic                  in_xfer;
  logic                  out_xfer;
  logic [TICK_BITS-1:0]  now_t;
  logic                  deb_start;
  logic                  deb_run;
  logic [TICK_BITS-1:0]  deb_from;
  logic                  deb_done;
  logic                  rot_ok;
  logic                  prev_key_level_next;
  logic                  key_is_pressed_next;
  logic                  debounce_active_next;
  logic [EVENT_BITS-1:0] rot_ev;
  logic [EVENT_BITS-1:0] key_ev;
  logic                  res_valid;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign now_t     = TICK_BITS'(now_tick);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_debounce_ticks   <= KEY_DEBOUNCE_RESET;
      rotate_holdoff_ticks <= ROTATE_HOLDOFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_DEBOUNCE:   key_debounce_ticks   <= cfg_data;
        REG_ROTATE_HOLDOFF: rotate_holdoff_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // key debounce and rotation step decode
  always_comb begin
    deb_start = (prev_key_level != key_level) && !debounce_active;
    deb_run   = debounce_active || deb_start;
    deb_from  = deb_start ? now_t : debounce_start_tick;
    deb_done  = (now_t - deb_from) >= TICK_BITS'(key_debounce_ticks);
    rot_ok    = (now_t - last_rotate_tick) >= TICK_BITS'(rotate_holdoff_ticks);

    prev_key_level_next  = prev_key_level;
    key_is_pressed_next  = key_is_pressed;
    debounce_active_next = debounce_active;
    key_ev               = KEY_NONE;
    rot_ev               = ROT_NONE;

    if (deb_run) begin
      if (deb_done) begin
        if (prev_key_level != key_recheck) begin
          if (!key_recheck && !key_is_pressed) begin
            key_ev              = KEY_PRESS;
            key_is_pressed_next = 1'b1;
          end else if (key_recheck && key_is_pressed) begin
            key_ev              = KEY_RELEASE;
            key_is_pressed_next = 1'b0;
          end
          prev_key_level_next = key_recheck;
        end
        debounce_active_next = 1'b0;
      end else begin
        debounce_active_next = 1'b1;
      end
    end else begin
      prev_key_level_next = key_level;
    end

    if (key_ev == KEY_NONE && !debounce_active_next && rot_ok && prev_phase_a && !phase_a) begin
      rot_ev = phase_b ? ROT_RIGHT : ROT_LEFT;
    end

    res_valid = in_xfer && ((key_ev != KEY_NONE) || (rot_ev != ROT_NONE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_phase_a        <= 1'b1;
      prev_key_level      <= 1'b1;
      key_is_pressed      <= 1'b0;
      debounce_active     <= 1'b0;
      debounce_start_tick <= '0;
      last_rotate_tick    <= '0;
    end else if (in_xfer) begin
      prev_phase_a    <= phase_a;
      prev_key_level  <= prev_key_level_next;
      key_is_pressed  <= key_is_pressed_next;
      debounce_active <= debounce_active_next;
      if (deb_start) begin
        debounce_start_tick <= now_t;
      end
      if (rot_ev != ROT_NONE) begin
        last_rotate_tick <= now_t;
      end
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_xfer) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_xfer) begin
      out_valid <= res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_xfer) begin
        rotate_event <= skid_rotate;
        key_event    <= skid_key;
      end
    end else if (!out_valid || out_xfer) begin
      rotate_event <= rot_ev;
      key_event    <= key_ev;
    end else if (res_valid) begin
      skid_rotate <= rot_ev;
      skid_key    <= key_ev;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a result in the output register");

  a_one_event_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((rotate_event != ROT_NONE) != (key_event != KEY_NONE)))
    else $error("result must carry exactly one of rotation or key event");

  a_skid_no_accept: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_xfer |=> skid_valid && $stable(skid_rotate) && $stable(skid_key))
    else $error("skid entry lost or overwritten while output stalled");

endmodule

// ===== verif/tb_rotary_encoder_key_decoder_unit.sv =====
// testbench for rotary_encoder_key_decoder_unit: directed and random encoder polls,
// a scoreboard class that predicts key and rotation events and checks each result
// depends on reckd_pkg and rotary_encoder_key_decoder_unit
`timescale 1ns / 1ps

module tb_rotary_encoder_key_decoder_unit;
  import reckd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_POLLS = 235;
  localparam int PHASE_COUNT = 7;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INDEX_TOP = 8'hFF;
  // quadrature order: stepping up gives right turns, stepping down gives left turns
  localparam logic [1:0] QUAD_SEQ [4] = '{2'b11, 2'b01, 2'b00, 2'b10};

  typedef struct packed {
    logic                phase_a;
    logic                phase_b;
    logic                key_level;
    logic                key_recheck;
    logic [NOW_BITS-1:0] now_tick;
  } poll_t;

  typedef struct packed {
    logic [EVENT_BITS-1:0] rotate_event;
    logic [EVENT_BITS-1:0] key_event;
  } encoder_result_t;

  class encoder_scoreboard;
    encoder_result_t expected_q[$];
    logic [CFG_DATA_BITS-1:0] debounce_ticks;
    logic [CFG_DATA_BITS-1:0] holdoff_ticks;
    logic prev_a;
    logic prev_key;
    logic pressed;
    logic debouncing;
    logic [NOW_BITS-1:0] debounce_start;
    logic [NOW_BITS-1:0] last_step;
    int errors;

    function new();
      debounce_ticks = KEY_DEBOUNCE_RESET;
      holdoff_ticks = ROTATE_HOLDOFF_RESET;
      prev_a = 1'b1;
      prev_key = 1'b1;
      pressed = 1'b0;
      debouncing = 1'b0;
      debounce_start = '0;
      last_step = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_KEY_DEBOUNCE) debounce_ticks = data;
      else if (idx == REG_ROTATE_HOLDOFF) holdoff_ticks = data;
    endfunction

    function void note_poll(poll_t p);
      encoder_result_t r;
      logic [NOW_BITS-1:0] elapsed;
      r.rotate_event = ROT_NONE;
      r.key_event = KEY_NONE;
      if (prev_key != p.key_level && !debouncing) begin
        debounce_start = p.now_tick;
        debouncing = 1'b1;
      end
      if (debouncing) begin
        elapsed = p.now_tick - debounce_start;
        if (elapsed >= NOW_BITS'(debounce_ticks)) begin
          if (prev_key != p.key_recheck) begin
            if (!p.key_recheck && !pressed) begin
              r.key_event = KEY_PRESS;
              pressed = 1'b1;
            end else if (p.key_recheck && pressed) begin
              r.key_event = KEY_RELEASE;
              pressed = 1'b0;
            end
            prev_key = p.key_recheck;
          end
          debouncing = 1'b0;
        end
      end else begin
        prev_key = p.key_level;
      end
      if (r.key_event == KEY_NONE && !debouncing) begin
        elapsed = p.now_tick - last_step;
        if (elapsed >= NOW_BITS'(holdoff_ticks) && prev_a && !p.phase_a) begin
          r.rotate_event = p.phase_b ? ROT_RIGHT : ROT_LEFT;
          last_step = p.now_tick;
        end
      end
      prev_a = p.phase_a;
      if (r.rotate_event != ROT_NONE || r.key_event != KEY_NONE) expected_q.push_back(r);
    endfunction

    function void check_event(logic [EVENT_BITS-1:0] rot, logic [EVENT_BITS-1:0] key);
      encoder_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: rotate_event %0d, key_event %0d", rot, key);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (rot !== exp_r.rotate_event) begin
        $error("rotate_event: expected %0d, actual %0d", exp_r.rotate_event, rot);
        errors++;
      end
      if (key !== exp_r.key_event) begin
        $error("key_event: expected %0d, actual %0d", exp_r.key_event, key);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic phase_a = 1'b1;
  logic phase_b = 1'b1;
  logic key_level = 1'b1;
  logic key_recheck = 1'b1;
  logic [NOW_BITS-1:0] now_tick = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [EVENT_BITS-1:0] rotate_event;
  logic [EVENT_BITS-1:0] key_event;

  encoder_scoreboard sb;
  bit idling = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;
  logic [NOW_BITS-1:0] tick_now = '0;
  int step_max = 3;
  logic [1:0] quad_idx = 2'd0;
  bit spin_up = 1'b1;
  logic key_target = 1'b1;

  rotary_encoder_key_decoder_unit i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .phase_a(phase_a),
    .phase_b(phase_b),
    .key_level(key_level),
    .key_recheck(key_recheck),
    .now_tick(now_tick),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rotate_event(rotate_event),
    .key_event(key_event)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // transfer monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        sb.note_poll('{phase_a, phase_b, key_level, key_recheck, now_tick});
      if (out_valid && !out_stall) sb.check_event(rotate_event, key_event);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_poll(input poll_t p);
    in_valid <= 1'b1;
    phase_a <= p.phase_a;
    phase_b <= p.phase_b;
    key_level <= p.key_level;
    key_recheck <= p.key_recheck;
    now_tick <= p.now_tick;
    do @(posedge clk); while (in_stall);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic poll(input logic a, input logic b, input logic k, input logic rc,
                      input logic [NOW_BITS-1:0] t);
    send_poll('{a, b, k, rc, t});
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input logic [CFG_DATA_BITS-1:0] debounce,
                               input logic [CFG_DATA_BITS-1:0] holdoff);
    write_reg(REG_KEY_DEBOUNCE, debounce);
    if ($urandom_range(0, 1) == 0)
      write_reg(CFG_INDEX_BITS'($urandom_range(REG_UNUSED, REG_INDEX_TOP)),
                CFG_DATA_BITS'($urandom()));
    write_reg(REG_ROTATE_HOLDOFF, holdoff);
    cfg_valid <= 1'b0;
    step_max = ((debounce > holdoff) ? debounce : holdoff) / 4 + 3;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly clean quadrature steps and key changes, some raw noise
  function automatic poll_t next_poll();
    poll_t p;
    if ($urandom_range(0, 39) == 0) tick_now = $urandom();
    else tick_now = tick_now + $urandom_range(0, step_max);
    if ($urandom_range(0, 99) < 80) begin
      if ($urandom_range(0, 19) == 0) spin_up = ~spin_up;
      if ($urandom_range(0, 2) != 0) quad_idx = spin_up ? quad_idx + 2'd1 : quad_idx - 2'd1;
      if ($urandom_range(0, 14) == 0) key_target = ~key_target;
      {p.phase_a, p.phase_b} = QUAD_SEQ[quad_idx];
      p.key_level = key_target;
      p.key_recheck = ($urandom_range(0, 9) == 0) ? ~key_target : key_target;
    end else begin
      {p.phase_a, p.phase_b, p.key_level, p.key_recheck} = 4'($urandom_range(0, 15));
    end
    p.now_tick = tick_now;
    return p;
  endfunction

  initial begin
    logic [CFG_DATA_BITS-1:0] debounce;
    logic [CFG_DATA_BITS-1:0] holdoff;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default settings: steps, holdoff, press and release, debounce blocking rotation
    poll(1, 1, 1, 1, 32'd0);
    poll(0, 1, 1, 1, 32'd5);
    poll(1, 1, 1, 1, 32'd6);
    poll(0, 0, 1, 1, 32'd8);
    poll(1, 0, 1, 1, 32'd9);
    poll(0, 0, 1, 1, 32'd13);
    poll(1, 1, 0, 0, 32'd20);
    poll(0, 1, 0, 0, 32'd30);
    poll(1, 1, 0, 0, 32'd70);
    poll(1, 1, 1, 1, 32'd100);
    poll(1, 1, 1, 0, 32'd149);
    poll(1, 1, 1, 1, 32'd150);
    // bounce that settles back, then a step once the window closes
    poll(1, 1, 0, 1, 32'd200);
    poll(0, 0, 0, 1, 32'd250);
    // tick wrap
    poll(1, 1, 1, 1, 32'hFFFF_FFFF);
    poll(0, 1, 1, 1, 32'd3);
    wait_idle();

    // zero debounce and holdoff, writes to unused indexes ignored
    write_reg(REG_KEY_DEBOUNCE, 16'd0);
    write_reg(REG_UNUSED, 16'd0);
    write_reg(REG_ROTATE_HOLDOFF, 16'd0);
    write_reg(REG_INDEX_TOP, 16'hFFFF);
    cfg_valid <= 1'b0;
    poll(1, 1, 0, 0, 32'd10);
    poll(0, 1, 0, 0, 32'd10);
    poll(1, 1, 1, 1, 32'd10);
    poll(0, 0, 0, 0, 32'd11);
    poll(1, 0, 1, 0, 32'd11);
    poll(0, 1, 1, 1, 32'd11);
    wait_idle();

    tick_now = 32'hFFFF_F000;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin debounce = 16'hFFFF; holdoff = 16'hFFFF; end
        1: begin debounce = 16'd1; holdoff = 16'd0; end
        2: begin debounce = 16'd0; holdoff = 16'hFFFF; end
        3: begin
          debounce = CFG_DATA_BITS'($urandom_range(0, 200));
          holdoff = CFG_DATA_BITS'($urandom_range(0, 50));
        end
        4: begin
          debounce = CFG_DATA_BITS'($urandom());
          holdoff = CFG_DATA_BITS'($urandom());
        end
        5: begin debounce = 16'd0; holdoff = 16'd0; end
        default: begin
          debounce = KEY_DEBOUNCE_RESET;
          holdoff = ROTATE_HOLDOFF_RESET;
          idling <= 1'b0;
        end
      endcase
      load_settings(debounce, holdoff);
      repeat (PHASE_POLLS) send_poll(next_poll());
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
